>>> src/sle_pkg.sv
package sle_pkg;

   // Command kinds passed from the front end to the back end
   typedef enum logic [1:0] {
      OP_CHAR      = 2'd0,
      OP_BACKSPACE = 2'd1,
      OP_ENTER     = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [6:0]  ch;
   } cmd_type;

   // Result action codes
   localparam logic [1:0] ACT_ECHO  = 2'd0;
   localparam logic [1:0] ACT_ERASE = 2'd1;
   localparam logic [1:0] ACT_LINE  = 2'd2;
   localparam logic [1:0] ACT_EOL   = 2'd3;

   localparam logic [6:0] CH_BACKSPACE = 7'h08;
   localparam logic [6:0] CH_ENTER     = 7'h0A;
   localparam logic [6:0] CH_NONE      = 7'h00;

   localparam logic [6:0] CAPACITY_RESET = 7'd64;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LINE,
      BK_EOL
   } back_state_type;

   // Set-1 make code to ASCII; zero means no character
   function automatic logic [6:0] key_map(input logic [6:0] code);
      logic [6:0] ch;
      ch = CH_NONE;
      case (code)
         7'd1:    ch = 7'h1B;
         7'd2:    ch = 7'h31;
         7'd3:    ch = 7'h32;
         7'd4:    ch = 7'h33;
         7'd5:    ch = 7'h34;
         7'd6:    ch = 7'h35;
         7'd7:    ch = 7'h36;
         7'd8:    ch = 7'h37;
         7'd9:    ch = 7'h38;
         7'd10:   ch = 7'h39;
         7'd11:   ch = 7'h30;
         7'd12:   ch = 7'h2D;
         7'd13:   ch = 7'h3D;
         7'd14:   ch = CH_BACKSPACE;
         7'd15:   ch = 7'h09;
         7'd16:   ch = 7'h71;
         7'd17:   ch = 7'h77;
         7'd18:   ch = 7'h65;
         7'd19:   ch = 7'h72;
         7'd20:   ch = 7'h74;
         7'd21:   ch = 7'h79;
         7'd22:   ch = 7'h75;
         7'd23:   ch = 7'h69;
         7'd24:   ch = 7'h6F;
         7'd25:   ch = 7'h70;
         7'd26:   ch = 7'h5B;
         7'd27:   ch = 7'h5D;
         7'd28:   ch = CH_ENTER;
         7'd30:   ch = 7'h61;
         7'd31:   ch = 7'h73;
         7'd32:   ch = 7'h64;
         7'd33:   ch = 7'h66;
         7'd34:   ch = 7'h67;
         7'd35:   ch = 7'h68;
         7'd36:   ch = 7'h6A;
         7'd37:   ch = 7'h6B;
         7'd38:   ch = 7'h6C;
         7'd39:   ch = 7'h3B;
         7'd40:   ch = 7'h27;
         7'd41:   ch = 7'h60;
         7'd43:   ch = 7'h5C;
         7'd44:   ch = 7'h7A;
         7'd45:   ch = 7'h78;
         7'd46:   ch = 7'h63;
         7'd47:   ch = 7'h76;
         7'd48:   ch = 7'h62;
         7'd49:   ch = 7'h6E;
         7'd50:   ch = 7'h6D;
         7'd51:   ch = 7'h2C;
         7'd52:   ch = 7'h2E;
         7'd53:   ch = 7'h2F;
         7'd55:   ch = 7'h2A;
         7'd57:   ch = 7'h20;
         default: ch = CH_NONE;
      endcase
      return ch;
   endfunction

endpackage

>>> src/scancode_line_editor.sv
// Line editor fed by PS/2 set-1 scan codes.
// req_*: one scan code byte per transfer. Releases and keys without a
//   character are taken and dropped without a result.
// rsp_*: results. A character key gives an echo if the line has room,
//   Backspace an erase if it is not empty, Enter every stored character
//   as a line character and then an end-of-line result with tlast high.
//   tlast marks the final result of each scan code; tuser carries the action.
// csr_*: line capacity write (reset 64); at most capacity-1 characters are
//   kept. Write it only while no result is pending.
// Flow: a scan code is classified in its transfer cycle and queued in a
//   two-entry command queue; the back end takes it when idle with its
//   output free, and the result shows on rsp_* the cycle after. Enter on
//   a non-empty line first addresses the line store, then gives one line
//   character per result from its read port, then the end-of-line result.
// Stall: rsp_* holds its result until taken; the queue keeps accepting scan
//   codes until two commands wait. Reset empties the line and the queue;
//   the line store itself is not cleared.
module scancode_line_editor #(
   parameter int LINE_DEPTH = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] character, [7] zero
   output logic [1:0]  rsp_tuser,   // [1:0] action
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // line_capacity
);
   import sle_pkg::*;

   logic       push_valid, push_ready;
   cmd_type    push_cmd;
   logic       pop_valid, pop_ready;
   cmd_type    pop_cmd;
   logic [6:0] capacity_ff;
   logic [1:0] out_action;
   logic [6:0] out_char;

   // Capacity register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   sle_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   sle_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   sle_back #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .cmd_valid  (pop_valid),
      .cmd_ready  (pop_ready),
      .cmd        (pop_cmd),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_action (out_action),
      .out_char   (out_char),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_char};
   assign rsp_tuser = out_action;

endmodule

>>> src/sle_ram.sv
module sle_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 63
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/sle_front.sv
module sle_front (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   output logic             push_valid,
   input  logic             push_ready,
   output sle_pkg::cmd_type push_cmd
);
   import sle_pkg::*;

   logic [6:0] mapped;
   logic       keep;

   // Drop releases and unmapped keys; sort the rest into commands
   always_comb begin
      mapped          = key_map(req_tdata[6:0]);
      keep            = !req_tdata[7] && (mapped != CH_NONE);
      push_cmd.ch     = mapped;
      push_cmd.op     = OP_CHAR;
      unique case (mapped)
         CH_BACKSPACE: push_cmd.op = OP_BACKSPACE;
         CH_ENTER:     push_cmd.op = OP_ENTER;
         default:      push_cmd.op = OP_CHAR;
      endcase
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid && keep;

endmodule

>>> src/sle_fifo.sv
module sle_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  sle_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output sle_pkg::cmd_type pop_cmd
);
   import sle_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> src/sle_back.sv
module sle_back #(
   parameter int LINE_DEPTH = 63
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [6:0]       capacity,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  sle_pkg::cmd_type cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [1:0]       out_action,
   output logic [6:0]       out_char,
   output logic             out_last
);
   import sle_pkg::*;

   localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int FW = $clog2(LINE_DEPTH + 1);

   back_state_type state_ff, state_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           valid_ff, valid_in;
   logic [1:0]     action_ff, action_in;
   logic [6:0]     char_ff, char_in;
   logic           last_ff, last_in;

   logic           slot_free;
   logic [6:0]     limit;
   logic           wr_en;
   logic [6:0]     rd_data;
   logic           last_char;

   // Usable characters: capacity minus one, saturated to the store depth
   always_comb begin
      if (capacity == 7'd0) begin
         limit = 7'd0;
      end else if ((capacity - 7'd1) > 7'(LINE_DEPTH)) begin
         limit = 7'(LINE_DEPTH);
      end else begin
         limit = capacity - 7'd1;
      end
   end

   assign slot_free = !valid_ff || out_ready;
   assign last_char = (FW'(idx_ff) + FW'(1)) == fill_ff;

   // Command sequencer and output register load
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff && !out_ready;
      action_in = action_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      cmd_ready = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_ready = slot_free;
            if (cmd_valid && slot_free) begin
               unique case (cmd.op)
                  OP_CHAR: begin
                     if (7'(fill_ff) < limit) begin
                        wr_en     = 1'b1;
                        fill_in   = fill_ff + FW'(1);
                        valid_in  = 1'b1;
                        action_in = ACT_ECHO;
                        char_in   = cmd.ch;
                        last_in   = 1'b1;
                     end
                  end
                  OP_BACKSPACE: begin
                     if (fill_ff != '0) begin
                        fill_in   = fill_ff - FW'(1);
                        valid_in  = 1'b1;
                        action_in = ACT_ERASE;
                        char_in   = CH_NONE;
                        last_in   = 1'b1;
                     end
                  end
                  OP_ENTER: begin
                     if (fill_ff == '0) begin
                        valid_in  = 1'b1;
                        action_in = ACT_EOL;
                        char_in   = CH_NONE;
                        last_in   = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = BK_LINE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_LINE: begin
            // the store read is registered on idx_in, so rd_data holds the character at idx_ff
            if (slot_free) begin
               valid_in  = 1'b1;
               action_in = ACT_LINE;
               char_in   = rd_data;
               last_in   = 1'b0;
               if (last_char) begin
                  state_in = BK_EOL;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         BK_EOL: begin
            if (slot_free) begin
               valid_in  = 1'b1;
               action_in = ACT_EOL;
               char_in   = CH_NONE;
               last_in   = 1'b1;
               fill_in   = '0;
               state_in  = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      action_ff <= action_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   sle_ram #(
      .WIDTH (7),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (cmd.ch),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign out_valid  = valid_ff;
   assign out_action = action_ff;
   assign out_char   = char_ff;
   assign out_last   = last_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(LINE_DEPTH))
      else $error("fill count beyond store depth");

   a_line_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (action_ff == ACT_LINE) |-> !last_ff)
      else $error("line character marked last");

   a_other_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (action_ff != ACT_LINE) |-> last_ff)
      else $error("single result not marked last");

   a_idx_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_LINE) |-> (FW'(idx_ff) < fill_ff))
      else $error("stream index past fill count");

   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_EOL) && slot_free |=> (fill_ff == '0) && (state_ff == BK_IDLE))
      else $error("end of line did not empty the line");

endmodule
